/* design/obb_pkg.sv */
// Shared types, constants and helpers for the oriented-box to AABB pipeline.
// No dependencies.
package obb_pkg;

  typedef logic signed [31:0] coord_t;   // Q16.16 coordinate
  typedef logic signed [15:0] quat_t;    // Q2.14 quaternion part
  typedef logic        [30:0] dim_t;     // unsigned Q16.16 full size
  typedef logic signed [31:0] prod_t;    // quaternion product, Q4.28
  typedef logic signed [34:0] rwide_t;   // signed matrix entry, 2^-28 scale
  typedef logic        [32:0] rmag_t;    // |matrix entry|
  typedef logic        [63:0] term_t;    // |R_ij| * size_j
  typedef logic        [65:0] sum_t;     // three terms plus rounding
  typedef logic        [36:0] ext_t;     // extent, Q16.16, unsigned
  typedef logic signed [38:0] bwide_t;   // centre +- extent, exact

  localparam int NAXIS   = 3;
  localparam int NMAT    = NAXIS * NAXIS;
  localparam int EXT_SHIFT = 29;          // halve sizes, drop matrix scale
  localparam rwide_t ONE_Q28 = rwide_t'(64'sd1 <<< 28);
  localparam sum_t   CEIL_ADD = sum_t'((66'd1 << EXT_SHIFT) - 66'd1);
  localparam bwide_t SAT_MAX = bwide_t'(64'sd2147483647);
  localparam bwide_t SAT_MIN = bwide_t'(-64'sd2147483648);

  function automatic rmag_t mag_of(input rwide_t v);
    rwide_t a;
    a = (v < 0) ? -v : v;
    return a[32:0];
  endfunction

  function automatic coord_t sat32(input bwide_t v);
    coord_t r;
    if (v > SAT_MAX) begin
      r = coord_t'(SAT_MAX[31:0]);
    end else if (v < SAT_MIN) begin
      r = coord_t'(SAT_MIN[31:0]);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/obb_rot.sv */
// Quaternion to rotation magnitudes: products stage, then |R| stage.
// Depends on obb_pkg.
module obb_rot (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  output logic                up_ready,
  input  logic                dn_ready,
  input  obb_pkg::coord_t     center_i [obb_pkg::NAXIS],
  input  obb_pkg::dim_t       size_i   [obb_pkg::NAXIS],
  input  obb_pkg::quat_t      qw,
  input  obb_pkg::quat_t      qx,
  input  obb_pkg::quat_t      qy,
  input  obb_pkg::quat_t      qz,
  output logic                out_vld,
  output obb_pkg::coord_t     center_o [obb_pkg::NAXIS],
  output obb_pkg::dim_t       size_o   [obb_pkg::NAXIS],
  output obb_pkg::rmag_t      rmag_o   [obb_pkg::NMAT]
);

  logic v1;
  logic rdy1, rdy2;
  obb_pkg::prod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
  obb_pkg::coord_t c1 [obb_pkg::NAXIS];
  obb_pkg::dim_t   s1 [obb_pkg::NAXIS];
  obb_pkg::rwide_t rw [obb_pkg::NMAT];

  assign rdy2     = !out_vld || dn_ready;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;

  // stage 1: the nine quaternion products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_vld;
    end
    if (rdy1 && in_vld) begin
      xx <= obb_pkg::prod_t'(obb_pkg::prod_t'(qx) * obb_pkg::prod_t'(qx));
      yy <= obb_pkg::prod_t'(obb_pkg::prod_t'(qy) * obb_pkg::prod_t'(qy));
      zz <= obb_pkg::prod_t'(obb_pkg::prod_t'(qz) * obb_pkg::prod_t'(qz));
      xy <= obb_pkg::prod_t'(obb_pkg::prod_t'(qx) * obb_pkg::prod_t'(qy));
      xz <= obb_pkg::prod_t'(obb_pkg::prod_t'(qx) * obb_pkg::prod_t'(qz));
      yz <= obb_pkg::prod_t'(obb_pkg::prod_t'(qy) * obb_pkg::prod_t'(qz));
      wx <= obb_pkg::prod_t'(obb_pkg::prod_t'(qw) * obb_pkg::prod_t'(qx));
      wy <= obb_pkg::prod_t'(obb_pkg::prod_t'(qw) * obb_pkg::prod_t'(qy));
      wz <= obb_pkg::prod_t'(obb_pkg::prod_t'(qw) * obb_pkg::prod_t'(qz));
      c1 <= center_i;
      s1 <= size_i;
    end
  end

  // matrix entries, row major
  always_comb begin
    rw[0] = obb_pkg::ONE_Q28 - ((obb_pkg::rwide_t'(yy) + obb_pkg::rwide_t'(zz)) <<< 1);
    rw[1] = (obb_pkg::rwide_t'(xy) - obb_pkg::rwide_t'(wz)) <<< 1;
    rw[2] = (obb_pkg::rwide_t'(xz) + obb_pkg::rwide_t'(wy)) <<< 1;
    rw[3] = (obb_pkg::rwide_t'(xy) + obb_pkg::rwide_t'(wz)) <<< 1;
    rw[4] = obb_pkg::ONE_Q28 - ((obb_pkg::rwide_t'(xx) + obb_pkg::rwide_t'(zz)) <<< 1);
    rw[5] = (obb_pkg::rwide_t'(yz) - obb_pkg::rwide_t'(wx)) <<< 1;
    rw[6] = (obb_pkg::rwide_t'(xz) - obb_pkg::rwide_t'(wy)) <<< 1;
    rw[7] = (obb_pkg::rwide_t'(yz) + obb_pkg::rwide_t'(wx)) <<< 1;
    rw[8] = obb_pkg::ONE_Q28 - ((obb_pkg::rwide_t'(xx) + obb_pkg::rwide_t'(yy)) <<< 1);
  end

  // stage 2: magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (rdy2) begin
      out_vld <= v1;
    end
    if (rdy2 && v1) begin
      for (int k = 0; k < obb_pkg::NMAT; k++) begin
        rmag_o[k] <= obb_pkg::mag_of(rw[k]);
      end
      center_o <= c1;
      size_o   <= s1;
    end
  end

endmodule

/* design/obb_ext.sv */
// Extent per world axis: |R_ij|*size_j products, then rounded-up sum.
// Depends on obb_pkg.
module obb_ext (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  output logic                up_ready,
  input  logic                dn_ready,
  input  obb_pkg::coord_t     center_i [obb_pkg::NAXIS],
  input  obb_pkg::dim_t       size_i   [obb_pkg::NAXIS],
  input  obb_pkg::rmag_t      rmag_i   [obb_pkg::NMAT],
  output logic                out_vld,
  output obb_pkg::coord_t     center_o [obb_pkg::NAXIS],
  output obb_pkg::ext_t       ext_o    [obb_pkg::NAXIS]
);

  logic v3;
  logic rdy3, rdy4;
  obb_pkg::term_t  term [obb_pkg::NMAT];
  obb_pkg::coord_t c3   [obb_pkg::NAXIS];
  obb_pkg::sum_t   acc  [obb_pkg::NAXIS];

  assign rdy4     = !out_vld || dn_ready;
  assign rdy3     = !v3 || rdy4;
  assign up_ready = rdy3;

  // stage 3: nine 33x31 products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= in_vld;
    end
    if (rdy3 && in_vld) begin
      for (int i = 0; i < obb_pkg::NAXIS; i++) begin
        for (int j = 0; j < obb_pkg::NAXIS; j++) begin
          term[obb_pkg::NAXIS*i + j] <=
            obb_pkg::term_t'(rmag_i[obb_pkg::NAXIS*i + j]) * obb_pkg::term_t'(size_i[j]);
        end
      end
      c3 <= center_i;
    end
  end

  // ceil(sum / 2^29): add 2^29-1 before the shift
  always_comb begin
    for (int i = 0; i < obb_pkg::NAXIS; i++) begin
      acc[i] = obb_pkg::sum_t'(term[obb_pkg::NAXIS*i])
             + obb_pkg::sum_t'(term[obb_pkg::NAXIS*i + 1])
             + obb_pkg::sum_t'(term[obb_pkg::NAXIS*i + 2])
             + obb_pkg::CEIL_ADD;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (rdy4) begin
      out_vld <= v3;
    end
    if (rdy4 && v3) begin
      for (int i = 0; i < obb_pkg::NAXIS; i++) begin
        ext_o[i] <= acc[i][65:obb_pkg::EXT_SHIFT];
      end
      center_o <= c3;
    end
  end

endmodule

/* design/obb_box.sv */
// Output stage: centre -/+ extent, saturated to 32 bits, held until taken.
// Depends on obb_pkg.
module obb_box (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  output logic                up_ready,
  input  logic                dn_stall,
  input  obb_pkg::coord_t     center_i [obb_pkg::NAXIS],
  input  obb_pkg::ext_t       ext_i    [obb_pkg::NAXIS],
  output logic                out_vld,
  output obb_pkg::coord_t     lo_o     [obb_pkg::NAXIS],
  output obb_pkg::coord_t     hi_o     [obb_pkg::NAXIS]
);

  logic rdy5;
  obb_pkg::bwide_t lo_w [obb_pkg::NAXIS];
  obb_pkg::bwide_t hi_w [obb_pkg::NAXIS];

  assign rdy5     = !out_vld || !dn_stall;
  assign up_ready = rdy5;

  always_comb begin
    for (int i = 0; i < obb_pkg::NAXIS; i++) begin
      lo_w[i] = obb_pkg::bwide_t'(center_i[i]) - obb_pkg::bwide_t'({2'b00, ext_i[i]});
      hi_w[i] = obb_pkg::bwide_t'(center_i[i]) + obb_pkg::bwide_t'({2'b00, ext_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (rdy5) begin
      out_vld <= in_vld;
    end
    if (rdy5 && in_vld) begin
      for (int i = 0; i < obb_pkg::NAXIS; i++) begin
        lo_o[i] <= obb_pkg::sat32(lo_w[i]);
        hi_o[i] <= obb_pkg::sat32(hi_w[i]);
      end
    end
  end

endmodule

/* design/obb_to_aabb_bounds_core.sv */
// Oriented box to axis-aligned bounding box, top level.
// Depends on obb_pkg, obb_rot, obb_ext and obb_box.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one oriented box per item:
//   centre (Q16.16), unit quaternion w,x,y,z (Q2.14) and full sizes
//   (unsigned Q16.16). Output channel (out_valid / out_stall) returns one
//   item per box: min and max corner, Q16.16, saturated to 32 bits.
//   An item moves on any rising edge where valid is high and stall low.
// Stages, each registered, from acceptance to out_valid:
//   1: quaternion products  2: |R| entries  3: |R_ij| * size_j
//   4: three-term sum, rounded up by 2^29  5: centre -/+ extent, saturate
// Throughput: one item per cycle while out_stall is low; the nine 33x31
//   multipliers of stage 3 and the 66-bit adders of stage 4 set the cycle time.
// Stall: each stage holds its item while the next stage is full and
//   blocked; empty stages still fill, so bubbles collapse. in_stall rises
//   only once every stage holds an item and out_stall is high.
// Reset: synchronous rst clears all stage valid bits; the block keeps no
//   state between items, so the next accepted box starts clean.
module obb_to_aabb_bounds_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  obb_pkg::coord_t center_x,
  input  obb_pkg::coord_t center_y,
  input  obb_pkg::coord_t center_z,
  input  obb_pkg::quat_t  quat_w,
  input  obb_pkg::quat_t  quat_x,
  input  obb_pkg::quat_t  quat_y,
  input  obb_pkg::quat_t  quat_z,
  input  obb_pkg::dim_t   size_w,
  input  obb_pkg::dim_t   size_h,
  input  obb_pkg::dim_t   size_d,
  output logic            out_valid,
  input  logic            out_stall,
  output obb_pkg::coord_t min_x,
  output obb_pkg::coord_t min_y,
  output obb_pkg::coord_t min_z,
  output obb_pkg::coord_t max_x,
  output obb_pkg::coord_t max_y,
  output obb_pkg::coord_t max_z
);

  // inputs gathered per axis
  obb_pkg::coord_t center_in [obb_pkg::NAXIS];
  obb_pkg::dim_t   size_in   [obb_pkg::NAXIS];

  // rotation -> extent
  logic            rot_vld, rot_ready;
  obb_pkg::coord_t rot_center [obb_pkg::NAXIS];
  obb_pkg::dim_t   rot_size   [obb_pkg::NAXIS];
  obb_pkg::rmag_t  rot_mag    [obb_pkg::NMAT];

  // extent -> output stage
  logic            ext_vld, ext_ready;
  obb_pkg::coord_t ext_center [obb_pkg::NAXIS];
  obb_pkg::ext_t   ext_val    [obb_pkg::NAXIS];

  logic            box_ready;
  obb_pkg::coord_t box_lo [obb_pkg::NAXIS];
  obb_pkg::coord_t box_hi [obb_pkg::NAXIS];

  assign center_in[0] = center_x;
  assign center_in[1] = center_y;
  assign center_in[2] = center_z;
  assign size_in[0]   = size_w;
  assign size_in[1]   = size_h;
  assign size_in[2]   = size_d;

  assign in_stall = !rot_ready;

  // stages 1-2
  obb_rot u_rot (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_valid),
    .up_ready (rot_ready),
    .dn_ready (ext_ready),
    .center_i (center_in),
    .size_i   (size_in),
    .qw       (quat_w),
    .qx       (quat_x),
    .qy       (quat_y),
    .qz       (quat_z),
    .out_vld  (rot_vld),
    .center_o (rot_center),
    .size_o   (rot_size),
    .rmag_o   (rot_mag)
  );

  // stages 3-4
  obb_ext u_ext (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rot_vld),
    .up_ready (ext_ready),
    .dn_ready (box_ready),
    .center_i (rot_center),
    .size_i   (rot_size),
    .rmag_i   (rot_mag),
    .out_vld  (ext_vld),
    .center_o (ext_center),
    .ext_o    (ext_val)
  );

  // stage 5, doubles as the output register
  obb_box u_box (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (ext_vld),
    .up_ready (box_ready),
    .dn_stall (out_stall),
    .center_i (ext_center),
    .ext_i    (ext_val),
    .out_vld  (out_valid),
    .lo_o     (box_lo),
    .hi_o     (box_hi)
  );

  assign min_x = box_lo[0];
  assign min_y = box_lo[1];
  assign min_z = box_lo[2];
  assign max_x = box_hi[0];
  assign max_y = box_hi[1];
  assign max_z = box_hi[2];

endmodule

/* tb/obb_bounds_checker.sv */
`timescale 1ns / 100ps
// Bounds checker for obb_to_aabb_bounds_core: watches both channels, predicts
// the axis-aligned box of every accepted item and compares results in order.
// Depends on obb_pkg for the port types.
module obb_bounds_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  obb_pkg::coord_t center_x,
  input  obb_pkg::coord_t center_y,
  input  obb_pkg::coord_t center_z,
  input  obb_pkg::quat_t  quat_w,
  input  obb_pkg::quat_t  quat_x,
  input  obb_pkg::quat_t  quat_y,
  input  obb_pkg::quat_t  quat_z,
  input  obb_pkg::dim_t   size_w,
  input  obb_pkg::dim_t   size_h,
  input  obb_pkg::dim_t   size_d,
  input  logic            out_valid,
  input  logic            out_stall,
  input  obb_pkg::coord_t min_x,
  input  obb_pkg::coord_t min_y,
  input  obb_pkg::coord_t min_z,
  input  obb_pkg::coord_t max_x,
  input  obb_pkg::coord_t max_y,
  input  obb_pkg::coord_t max_z,
  output int              mismatch_count,
  output int              boxes_in_flight
);

  localparam logic signed [63:0] ROT_UNIT   = 64'sd1 <<< 28;  // 1.0 at 2^-28
  localparam int                 HALF_SHIFT = 29;             // /2 sizes, /2^28 matrix
  localparam logic [67:0]        CEIL_BIAS  = (68'd1 << HALF_SHIFT) - 68'd1;

  typedef struct packed {
    obb_pkg::coord_t lo_x, lo_y, lo_z;
    obb_pkg::coord_t hi_x, hi_y, hi_z;
  } aabb_t;

  aabb_t bounds_due [$];

  function automatic obb_pkg::coord_t clamp_q16(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return obb_pkg::coord_t'(32'h7FFF_FFFF);
    if (v < -64'sd2147483648) return obb_pkg::coord_t'(32'h8000_0000);
    return obb_pkg::coord_t'(v[31:0]);
  endfunction

  function automatic aabb_t predict_bounds(
    input obb_pkg::coord_t cx, cy, cz,
    input obb_pkg::quat_t  qw, qx, qy, qz,
    input obb_pkg::dim_t   sw, sh, sd
  );
    logic signed [63:0] w, x, y, z;
    logic signed [63:0] rot [9];
    logic signed [63:0] ctr [3];
    logic        [63:0] dim [3];
    logic        [63:0] mag;
    logic        [67:0] acc;
    logic signed [63:0] reach;
    obb_pkg::coord_t lo [3];
    obb_pkg::coord_t hi [3];
    aabb_t res;
    w = qw; x = qx; y = qy; z = qz;
    ctr[0] = cx; ctr[1] = cy; ctr[2] = cz;
    dim[0] = sw; dim[1] = sh; dim[2] = sd;
    // rotation matrix from the quaternion, no normalization
    rot[0] = ROT_UNIT - 2 * (y * y + z * z);
    rot[1] = 2 * (x * y - w * z);
    rot[2] = 2 * (x * z + w * y);
    rot[3] = 2 * (x * y + w * z);
    rot[4] = ROT_UNIT - 2 * (x * x + z * z);
    rot[5] = 2 * (y * z - w * x);
    rot[6] = 2 * (x * z - w * y);
    rot[7] = 2 * (y * z + w * x);
    rot[8] = ROT_UNIT - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        mag = (rot[3 * i + j] < 0) ? -rot[3 * i + j] : rot[3 * i + j];
        acc = acc + mag * dim[j];
      end
      acc   = (acc + CEIL_BIAS) >> HALF_SHIFT;   // extent, rounded up
      reach = $signed(acc[63:0]);
      lo[i] = clamp_q16(ctr[i] - reach);
      hi[i] = clamp_q16(ctr[i] + reach);
    end
    res.lo_x = lo[0]; res.lo_y = lo[1]; res.lo_z = lo[2];
    res.hi_x = hi[0]; res.hi_y = hi[1]; res.hi_z = hi[2];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] bounds mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name,
                             input obb_pkg::coord_t got,
                             input obb_pkg::coord_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    aabb_t want;
    if (rst) begin
      bounds_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bounds_due.size() == 0) begin
          report_mismatch("result with no box outstanding");
        end else begin
          want = bounds_due.pop_front();
          check_field("min_x", min_x, want.lo_x);
          check_field("min_y", min_y, want.lo_y);
          check_field("min_z", min_z, want.lo_z);
          check_field("max_x", max_x, want.hi_x);
          check_field("max_y", max_y, want.hi_y);
          check_field("max_z", max_z, want.hi_z);
        end
      end
      if (in_valid && !in_stall)
        bounds_due.push_back(predict_bounds(center_x, center_y, center_z,
                                            quat_w, quat_x, quat_y, quat_z,
                                            size_w, size_h, size_d));
    end
    boxes_in_flight <= bounds_due.size();
  end

endmodule

/* tb/obb_to_aabb_bounds_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for obb_to_aabb_bounds_core: drives boxes, idles both channels
// and gives the verdict. Depends on obb_pkg and obb_bounds_checker.
module obb_to_aabb_bounds_core_tb;

  localparam int RANDOM_BOXES = 1750;
  localparam int SQUEEZE_LEN  = 150;   // receiver hold-off, long enough to back up the pipe
  localparam int DRAIN_CYCLES = 20;    // margin after the checker drains, leave room for strays

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  obb_pkg::coord_t center_x, center_y, center_z;
  obb_pkg::quat_t  quat_w, quat_x, quat_y, quat_z;
  obb_pkg::dim_t   size_w, size_h, size_d;
  logic            out_valid;
  logic            out_stall;
  obb_pkg::coord_t min_x, min_y, min_z, max_x, max_y, max_z;
  int              mismatch_count;
  int              boxes_in_flight;

  // calm: stretch with no idling on either side
  // squeeze_req: ask the receiver for one long hold-off
  bit calm        = 1'b0;
  bit squeeze_req = 1'b0;

  always #5 clk = ~clk;

  obb_to_aabb_bounds_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .size_w   (size_w),
    .size_h   (size_h),
    .size_d   (size_d),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .min_x    (min_x),
    .min_y    (min_y),
    .min_z    (min_z),
    .max_x    (max_x),
    .max_y    (max_y),
    .max_z    (max_z)
  );

  obb_bounds_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .quat_w         (quat_w),
    .quat_x         (quat_x),
    .quat_y         (quat_y),
    .quat_z         (quat_z),
    .size_w         (size_w),
    .size_h         (size_h),
    .size_d         (size_d),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .min_x          (min_x),
    .min_y          (min_y),
    .min_z          (min_z),
    .max_x          (max_x),
    .max_y          (max_y),
    .max_z          (max_z),
    .mismatch_count (mismatch_count),
    .boxes_in_flight(boxes_in_flight)
  );

  // Sender gap: mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Centre: mostly moderate values, with full-range and near-limit picks
  // so the saturating adders get hit from both sides.
  function automatic obb_pkg::coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return obb_pkg::coord_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
      1:       return obb_pkg::coord_t'(32'h8000_0000 + $urandom_range(0, 3));
      2, 3:    return obb_pkg::coord_t'($urandom);
      default: return obb_pkg::coord_t'($urandom) >>> 4;   // within +-2048.0
    endcase
  endfunction

  // Sizes: mostly up to 1024.0, with tiny ones for the round-up and the
  // full 31-bit range for extents past 32 bits.
  function automatic obb_pkg::dim_t pick_dim();
    case ($urandom_range(0, 9))
      0:       return obb_pkg::dim_t'($urandom_range(0, 7));
      1:       return obb_pkg::dim_t'(31'h7FFF_FFFF - $urandom_range(0, 3));
      2:       return obb_pkg::dim_t'($urandom);
      default: return obb_pkg::dim_t'($urandom_range(0, 32'h0400_0000));
    endcase
  endfunction

  function automatic obb_pkg::quat_t extreme_part();
    case ($urandom_range(0, 4))
      0:       return obb_pkg::quat_t'(16'h8000);
      1:       return obb_pkg::quat_t'(16'h7FFF);
      2:       return obb_pkg::quat_t'(16'h4000);
      3:       return obb_pkg::quat_t'(16'hC000);
      default: return obb_pkg::quat_t'(16'h0000);
    endcase
  endfunction

  // Rotation: mostly unit quaternions (the normal use), then raw 16-bit
  // noise and the extreme codes, which exercise the unnormalized formula.
  function automatic void pick_quat(output obb_pkg::quat_t qw, qx, qy, qz);
    real a [4];
    real norm;
    int  mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        a[k] = real'(int'($urandom_range(0, 65536)) - 32768);
        norm = norm + a[k] * a[k];
      end
      if (norm == 0.0) begin
        a[0] = 1.0;
        norm = 1.0;
      end
      norm = 16384.0 / $sqrt(norm);
      qw = obb_pkg::quat_t'($rtoi(a[0] * norm));
      qx = obb_pkg::quat_t'($rtoi(a[1] * norm));
      qy = obb_pkg::quat_t'($rtoi(a[2] * norm));
      qz = obb_pkg::quat_t'($rtoi(a[3] * norm));
    end else if (mode < 9) begin
      qw = obb_pkg::quat_t'($urandom);
      qx = obb_pkg::quat_t'($urandom);
      qy = obb_pkg::quat_t'($urandom);
      qz = obb_pkg::quat_t'($urandom);
    end else begin
      qw = extreme_part();
      qx = extreme_part();
      qy = extreme_part();
      qz = extreme_part();
    end
  endfunction

  // Offer one box and hold it until the block takes it. Valid stays high
  // across back-to-back items; it only drops when a gap follows.
  task automatic offer_box(input obb_pkg::coord_t cx, cy, cz,
                           input obb_pkg::quat_t  qw, qx, qy, qz,
                           input obb_pkg::dim_t   sw, sh, sd);
    int gap;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    quat_w   <= qw;
    quat_x   <= qx;
    quat_y   <= qy;
    quat_z   <= qz;
    size_w   <= sw;
    size_h   <= sh;
    size_d   <= sd;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: directed corners first, then the random stream.
  initial begin
    obb_pkg::quat_t qw, qx, qy, qz;
    rst      = 1'b1;
    in_valid = 1'b0;
    center_x = '0; center_y = '0; center_z = '0;
    quat_w   = '0; quat_x   = '0; quat_y   = '0; quat_z = '0;
    size_w   = '0; size_h   = '0; size_d   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all zero: zero quaternion acts as identity, point box at origin
    offer_box('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    // identity, sizes 2,4,6 -> extents 1,2,3
    offer_box('0, '0, '0, 16'sh4000, '0, '0, '0,
              31'h0002_0000, 31'h0004_0000, 31'h0006_0000);
    // zero quaternion, off-center box
    offer_box(32'h0001_8000, -32'sh0002_4000, 32'h0003_0000, '0, '0, '0, '0,
              31'h0001_0000, 31'h0002_0000, 31'h0003_0000);
    // one-LSB sizes, then 3, 5 and 7 LSB: the half-LSB extents round up
    offer_box('0, '0, '0, 16'sh4000, '0, '0, '0, 31'd1, 31'd1, 31'd1);
    offer_box('0, '0, '0, 16'sh4000, '0, '0, '0, 31'd3, 31'd5, 31'd7);
    // 90 degrees about z (slightly short of unit)
    offer_box(32'h0010_0000, '0, '0, 16'sh2D41, '0, '0, 16'sh2D41,
              31'h0004_0000, 31'h0002_0000, '0);
    // half turns about x, y and z
    offer_box('0, '0, '0, '0, 16'sh4000, '0, '0,
              31'h0001_0000, 31'h0002_0000, 31'h0003_0000);
    offer_box('0, '0, '0, '0, '0, 16'sh4000, '0,
              31'h0001_0000, 31'h0002_0000, 31'h0003_0000);
    offer_box('0, '0, '0, '0, '0, '0, 16'sh4000,
              31'h0001_0000, 31'h0002_0000, 31'h0003_0000);
    // negative scalar part, same rotation as identity
    offer_box(-32'sh0005_0000, '0, 32'h0005_0000, -16'sh4000, '0, '0, '0,
              31'h0001_0000, 31'h0001_0000, 31'h0001_0000);
    // 90 degrees about x
    offer_box('0, '0, '0, 16'sh2D41, 16'sh2D41, '0, '0,
              31'h0064_0000, 31'h0064_0000, 31'h0064_0000);
    // extreme quaternion codes, far from unit, then one unit quaternion of halves
    offer_box('0, '0, '0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              31'h0001_0000, 31'h0001_0000, 31'h0001_0000);
    offer_box('0, '0, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    offer_box(32'h1234_5678, -32'sh0765_4321, 32'h0ABC_DEF0,
              16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
              31'h1357_9BDF, 31'h2468_ACE0, 31'h0FED_CBA9);
    offer_box('0, '0, '0, 16'sh2000, -16'sh2000, 16'sh2000, -16'sh2000,
              31'h0010_0000, 31'h0020_0000, 31'h0030_0000);
    // largest size, identity: extent 2^30 exactly after rounding
    offer_box('0, '0, '0, '0, '0, '0, '0,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    // centre at the top and bottom of range: each side saturates
    offer_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sh4000, '0, '0, '0,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    offer_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sh4000, '0, '0, '0,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    offer_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh2D41, 16'sh2D41, '0, '0,
              31'h0064_0000, 31'h0064_0000, 31'h0064_0000);
    // zero sizes at the range limits: bounds equal the centre
    offer_box(32'h8000_0000, 32'h7FFF_FFFF, '0, 16'sh1234, -16'sh0567, 16'sh0ABC, 16'sh3210,
              '0, '0, '0);

    // Random stream. Every 400 items a 100-item calm window runs with no
    // idling other than a requested hold-off; two long receiver hold-offs fill
    // the pipe while the sender keeps offering.
    for (int n = 0; n < RANDOM_BOXES; n++) begin
      calm = (n % 400) >= 300;
      if (n == 250 || n == 1100) squeeze_req = 1'b1;
      pick_quat(qw, qx, qy, qz);
      offer_box(pick_coord(), pick_coord(), pick_coord(), qw, qx, qy, qz,
                pick_dim(), pick_dim(), pick_dim());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // one edge first so the count includes the last accepted box
    do @(posedge clk); while (boxes_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("obb_to_aabb_bounds_core regression: pass");
    end else begin
      $display("obb_to_aabb_bounds_core regression: fail");
    end
    $finish;
  end

  // Receiver: random stalls with occasional bursts, none in calm windows,
  // plus the requested long hold-off counted here.
  initial begin
    int hold_left;
    int r;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SQUEEZE_LEN;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm || r < 65) begin
        out_stall <= 1'b0;
      end else if (r < 94) begin
        out_stall <= 1'b1;
      end else begin
        hold_left = $urandom_range(4, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // Hang guard: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("obb_to_aabb_bounds_core regression: fail");
    $finish;
  end

endmodule
